// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define TCB_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TCB_ASSERT_IMPL(name, ante, cons, msg)

`define TCB_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== rtl/core/tcb_pkg.sv =====
// ----------------------------------------------------------------------------
// tcb_pkg
// Types, codes and constants shared by the text cell buffer engine.
// ----------------------------------------------------------------------------
package tcb_pkg;

  localparam int COORD_W     = 8;
  localparam int CELL_W      = 16;
  localparam int IDX_W       = 16;
  localparam int COL_REG_W   = 7;
  localparam int ROW_REG_W   = 6;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int Q_DEPTH     = 2;
  localparam int DEF_MAX_COLS = 80;
  localparam int DEF_MAX_ROWS = 50;

  localparam logic [COL_REG_W-1:0] COL_REG_RESET = 7'd80;
  localparam logic [ROW_REG_W-1:0] ROW_REG_RESET = 6'd25;
  localparam logic [7:0]           BLANK_CHAR    = 8'h20;
  localparam logic [CELL_W-1:0]    RESET_CELL    = 16'h0720;

  // Register index, taken from paddr[2].
  localparam logic REG_COLUMN_COUNT = 1'b0;
  localparam logic REG_ROW_COUNT    = 1'b1;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_GET,
    CMD_FILL,
    CMD_CLEAR,
    CMD_SCROLL_UP,
    CMD_SCROLL_DOWN
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_GET,
    OP_FILL,
    OP_SCROLL_UP,
    OP_SCROLL_DOWN
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_GET,
    ST_TOTAL,
    ST_PTR,
    ST_COPY,
    ST_RECT,
    ST_DONE
  } state_t;

  // Active screen size after saturation.
  typedef struct packed {
    logic [COORD_W-1:0] cols;
    logic [COORD_W-1:0] rows;
  } geom_t;

  // One classified command as it sits in the queue. For a scroll, y_lo
  // holds the line count and addr the cell shift.
  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] x_lo;
    logic [COORD_W-1:0] x_hi;
    logic [COORD_W-1:0] y_lo;
    logic [COORD_W-1:0] y_hi;
    logic [IDX_W-1:0]   addr;
    logic [CELL_W-1:0]  value;
  } entry_t;

  typedef struct packed {
    logic init_done;
    logic pop;
  } back_stat_t;

  function automatic logic [CELL_W-1:0] blank_cell(input logic [7:0] attr);
    return {attr, BLANK_CHAR};
  endfunction

endpackage

// ===== rtl/core/tcb_front.sv =====
// ----------------------------------------------------------------------------
// tcb_front
// Accepts commands, clips them to the active screen and turns them into
// queue entries with their start address already worked out.
// ----------------------------------------------------------------------------
module tcb_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_command,
  input  logic [tcb_pkg::COORD_W-1:0]  in_col,
  input  logic [tcb_pkg::COORD_W-1:0]  in_row,
  input  logic [tcb_pkg::COORD_W-1:0]  in_rect_width,
  input  logic [tcb_pkg::COORD_W-1:0]  in_rect_height,
  input  logic [tcb_pkg::CELL_W-1:0]   in_cell_value,
  input  logic [tcb_pkg::COORD_W-1:0]  in_line_count,
  input  logic [7:0]                   in_attribute,
  input  tcb_pkg::geom_t               geom,
  input  logic                         q_full,
  input  logic                         init_done,
  output logic                         push,
  output tcb_pkg::entry_t              entry
);
  import tcb_pkg::*;

  logic               empty_scr;
  logic               on_screen;
  logic [COORD_W-1:0] col_end;
  logic [COORD_W-1:0] row_end;
  logic [COORD_W-1:0] col_hi;
  logic [COORD_W-1:0] row_hi;
  logic [COORD_W-1:0] mul_row;
  logic [COORD_W-1:0] mul_col;
  logic [CELL_W-1:0]  blank;

  assign in_ready = !q_full && init_done;
  assign push     = in_valid && in_ready;

  assign empty_scr = (geom.cols == '0) || (geom.rows == '0);
  assign on_screen = (in_col < geom.cols) && (in_row < geom.rows);
  // Rectangle ends wrap at 256 and are then clipped to the screen.
  assign col_end   = in_col + in_rect_width;
  assign row_end   = in_row + in_rect_height;
  assign col_hi    = (col_end < geom.cols) ? col_end : geom.cols;
  assign row_hi    = (row_end < geom.rows) ? row_end : geom.rows;
  assign blank     = blank_cell(in_attribute);

  always_comb begin
    entry.op    = OP_NOP;
    entry.x_lo  = '0;
    entry.x_hi  = geom.cols;
    entry.y_lo  = '0;
    entry.y_hi  = geom.rows;
    entry.value = in_cell_value;
    mul_row     = '0;
    mul_col     = '0;
    case (cmd_t'(in_command))
      CMD_PUT: begin
        mul_row = in_row;
        mul_col = in_col;
        if (on_screen) begin
          entry.op = OP_PUT;
        end
      end
      CMD_GET: begin
        mul_row = in_row;
        mul_col = in_col;
        if (on_screen) begin
          entry.op = OP_GET;
        end
      end
      CMD_FILL: begin
        mul_row    = in_row;
        mul_col    = in_col;
        entry.x_lo = in_col;
        entry.x_hi = col_hi;
        entry.y_lo = in_row;
        entry.y_hi = row_hi;
        if ((in_col < col_hi) && (in_row < row_hi)) begin
          entry.op = OP_FILL;
        end
      end
      CMD_CLEAR: begin
        entry.value = blank;
        if (!empty_scr) begin
          entry.op = OP_FILL;
        end
      end
      CMD_SCROLL_UP, CMD_SCROLL_DOWN: begin
        entry.value = blank;
        if (!empty_scr && (in_line_count != '0)) begin
          if (in_line_count >= geom.rows) begin
            // Scrolling the whole screen away is a clear.
            entry.op = OP_FILL;
          end else begin
            mul_row    = in_line_count;
            entry.y_lo = in_line_count;
            entry.op   = (cmd_t'(in_command) == CMD_SCROLL_UP) ? OP_SCROLL_UP
                                                               : OP_SCROLL_DOWN;
          end
        end
      end
      default: begin
        entry.op = OP_NOP;
      end
    endcase
    entry.addr = IDX_W'(mul_row) * IDX_W'(geom.cols) + IDX_W'(mul_col);
  end

endmodule

// ===== rtl/core/tcb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// tcb_cmd_fifo
// Short command queue between the front and the back, so that each side
// can stall without holding up the other.
// ----------------------------------------------------------------------------
module tcb_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcb_pkg::entry_t din,
  input  logic            pop,
  output tcb_pkg::entry_t head,
  output logic            empty,
  output logic            full
);
  import tcb_pkg::*;

  localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam logic [QP_W:0]   CNT_FULL = (QP_W + 1)'(Q_DEPTH);
  localparam logic [QP_W-1:0] PTR_LAST = QP_W'(Q_DEPTH - 1);

  entry_t          q_r [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QP_W:0]   cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_FULL);
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/core/tcb_back.sv =====
// ----------------------------------------------------------------------------
// tcb_back
// Cell store and the sequencer that carries out queued commands: single
// cell access, rectangle walks and the scroll copy.
// ----------------------------------------------------------------------------
module tcb_back #(
  parameter int MAX_COLS = tcb_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = tcb_pkg::DEF_MAX_ROWS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tcb_pkg::geom_t             geom,
  input  tcb_pkg::entry_t            head,
  input  logic                       q_empty,
  output tcb_pkg::back_stat_t        stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tcb_pkg::CELL_W-1:0] out_read_value
);
  import tcb_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [AW-1:0]     mem_ra;
  logic [CELL_W-1:0] mem_wd;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   addr_r, addr_nxt;
  logic [IDX_W-1:0]   row_addr_r, row_addr_nxt;
  logic [IDX_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [IDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0]   n_r, n_nxt;
  logic [IDX_W-1:0]   shift_r, shift_nxt;
  logic [IDX_W-1:0]   total_r, total_nxt;
  logic [COORD_W-1:0] x_r, x_nxt;
  logic [COORD_W-1:0] xlo_r, xlo_nxt;
  logic [COORD_W-1:0] xhi_r, xhi_nxt;
  logic [COORD_W-1:0] y_r, y_nxt;
  logic [COORD_W-1:0] yhi_r, yhi_nxt;
  logic [COORD_W-1:0] lines_r, lines_nxt;
  logic [CELL_W-1:0]  val_r, val_nxt;
  logic [CELL_W-1:0]  res_r, res_nxt;
  logic               up_r, up_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]  out_value_r, out_value_nxt;
  logic               slot_free;
  logic               finish;
  logic [CELL_W-1:0]  fin_val;
  logic               pop;

  assign slot_free      = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign stat.init_done = (state_r != ST_INIT);
  assign stat.pop       = pop;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    row_addr_nxt  = row_addr_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    n_nxt         = n_r;
    shift_nxt     = shift_r;
    total_nxt     = total_r;
    x_nxt         = x_r;
    xlo_nxt       = xlo_r;
    xhi_nxt       = xhi_r;
    y_nxt         = y_r;
    yhi_nxt       = yhi_r;
    lines_nxt     = lines_r;
    val_nxt       = val_r;
    res_nxt       = res_r;
    up_nxt        = up_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    mem_we        = 1'b0;
    mem_wa        = addr_r[AW-1:0];
    mem_wd        = val_r;
    mem_ra        = rd_ptr_r[AW-1:0];
    finish        = 1'b0;
    fin_val       = '0;
    pop           = 1'b0;

    case (state_r)
      ST_INIT: begin
        // Clearing pass over the whole store after reset.
        mem_we = 1'b1;
        mem_wd = RESET_CELL;
        if (addr_r == LAST_IDX) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        mem_ra = head.addr[AW-1:0];
        if (!q_empty) begin
          pop = 1'b1;
          case (head.op)
            OP_PUT: begin
              mem_we = 1'b1;
              mem_wa = head.addr[AW-1:0];
              mem_wd = head.value;
              finish = 1'b1;
            end
            OP_GET: begin
              state_nxt = ST_GET;
            end
            OP_FILL: begin
              x_nxt        = head.x_lo;
              xlo_nxt      = head.x_lo;
              xhi_nxt      = head.x_hi;
              y_nxt        = head.y_lo;
              yhi_nxt      = head.y_hi;
              addr_nxt     = head.addr;
              row_addr_nxt = head.addr;
              val_nxt      = head.value;
              state_nxt    = ST_RECT;
            end
            OP_SCROLL_UP, OP_SCROLL_DOWN: begin
              shift_nxt = head.addr;
              lines_nxt = head.y_lo;
              val_nxt   = head.value;
              up_nxt    = (head.op == OP_SCROLL_UP);
              state_nxt = ST_TOTAL;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_GET: begin
        finish  = 1'b1;
        fin_val = rdata_r;
      end
      ST_TOTAL: begin
        total_nxt = IDX_W'(geom.cols) * IDX_W'(geom.rows);
        state_nxt = ST_PTR;
      end
      ST_PTR: begin
        n_nxt    = total_r - shift_r;
        pend_nxt = 1'b0;
        if (up_r) begin
          rd_ptr_nxt = shift_r;
          wr_ptr_nxt = '0;
        end else begin
          rd_ptr_nxt = total_r - shift_r - 1'b1;
          wr_ptr_nxt = total_r - 1'b1;
        end
        state_nxt = ST_COPY;
      end
      ST_COPY: begin
        // Reads run ahead of writes, each write following its read in the next
        // cycle; the read data register carries each cell across.
        pend_nxt = (n_r != '0);
        if (n_r != '0) begin
          n_nxt      = n_r - 1'b1;
          rd_ptr_nxt = up_r ? rd_ptr_r + 1'b1 : rd_ptr_r - 1'b1;
        end
        if (pend_r) begin
          mem_we     = 1'b1;
          mem_wa     = wr_ptr_r[AW-1:0];
          mem_wd     = rdata_r;
          wr_ptr_nxt = up_r ? wr_ptr_r + 1'b1 : wr_ptr_r - 1'b1;
        end
        if ((n_r == '0) && !pend_r) begin
          // Blank the vacated lines with the rectangle walk.
          x_nxt        = '0;
          xlo_nxt      = '0;
          xhi_nxt      = geom.cols;
          y_nxt        = up_r ? geom.rows - lines_r : '0;
          yhi_nxt      = up_r ? geom.rows : lines_r;
          addr_nxt     = up_r ? wr_ptr_r : '0;
          row_addr_nxt = up_r ? wr_ptr_r : '0;
          state_nxt    = ST_RECT;
        end
      end
      ST_RECT: begin
        mem_we = 1'b1;
        if (x_r == xhi_r - 1'b1) begin
          if (y_r == yhi_r - 1'b1) begin
            finish = 1'b1;
          end else begin
            y_nxt        = y_r + 1'b1;
            x_nxt        = xlo_r;
            row_addr_nxt = row_addr_r + IDX_W'(geom.cols);
            addr_nxt     = row_addr_r + IDX_W'(geom.cols);
          end
        end else begin
          x_nxt    = x_r + 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (finish) begin
      if (slot_free) begin
        out_valid_nxt = 1'b1;
        out_value_nxt = fin_val;
        state_nxt     = ST_IDLE;
      end else begin
        res_nxt   = fin_val;
        state_nxt = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      addr_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_addr_r  <= row_addr_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    wr_ptr_r    <= wr_ptr_nxt;
    n_r         <= n_nxt;
    shift_r     <= shift_nxt;
    total_r     <= total_nxt;
    x_r         <= x_nxt;
    xlo_r       <= xlo_nxt;
    xhi_r       <= xhi_nxt;
    y_r         <= y_nxt;
    yhi_r       <= yhi_nxt;
    lines_r     <= lines_nxt;
    val_r       <= val_nxt;
    res_r       <= res_nxt;
    up_r        <= up_nxt;
    out_value_r <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

endmodule

// ===== rtl/core/text_cell_buffer_engine_unit.sv =====
// ----------------------------------------------------------------------------
// text_cell_buffer_engine_unit
// Character cell screen store with put, get, rectangle fill, clear and
// scroll commands, configured through an APB-style register port.
// ----------------------------------------------------------------------------
// After reset the store is swept to blank grey-on-black cells, one cell per
// cycle, over all MAX_COLS*MAX_ROWS cells (4000 with the defaults); in_ready
// stays low until the sweep ends, while register writes are taken as usual.
// All work goes through one cell memory with a write port and a registered
// read port. A put or an off-screen or unused command is carried out in the
// idle state; a get reads its cell there and returns it from the read data
// register in ST_GET. A fill or a clear first latches its rectangle and then
// writes one cell per cycle. A scroll by N lines works out the screen size
// and the copy pointers, moves the (rows-N)*cols kept cells and then blanks
// the N*cols cells of the vacated lines. A command that finishes while the
// previous result still waits in the output register holds the engine until
// that result is taken. A two-entry command queue keeps accepting transactions
// until it is full, while the engine is busy or a result waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_cell_buffer_engine_unit #(
  parameter int MAX_COLS = tcb_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = tcb_pkg::DEF_MAX_ROWS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcb_pkg::PADDR_W-1:0]   paddr,
  input  logic [tcb_pkg::PDATA_W-1:0]   pwdata,
  output logic [tcb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_command,
  input  logic [tcb_pkg::COORD_W-1:0]   in_col,
  input  logic [tcb_pkg::COORD_W-1:0]   in_row,
  input  logic [tcb_pkg::COORD_W-1:0]   in_rect_width,
  input  logic [tcb_pkg::COORD_W-1:0]   in_rect_height,
  input  logic [tcb_pkg::CELL_W-1:0]    in_cell_value,
  input  logic [tcb_pkg::COORD_W-1:0]   in_line_count,
  input  logic [7:0]                    in_attribute,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcb_pkg::CELL_W-1:0]    out_read_value
);
  import tcb_pkg::*;

  localparam logic [COORD_W-1:0] MAX_COLS_C = COORD_W'(MAX_COLS);
  localparam logic [COORD_W-1:0] MAX_ROWS_C = COORD_W'(MAX_ROWS);

  logic [COL_REG_W-1:0] column_count_r, column_count_nxt;
  logic [ROW_REG_W-1:0] row_count_r, row_count_nxt;
  logic                 cfg_wr;
  logic [COORD_W-1:0]   cols_ext;
  logic [COORD_W-1:0]   rows_ext;
  geom_t                geom;
  entry_t               entry;
  entry_t               head;
  logic                 push;
  logic                 q_empty;
  logic                 q_full;
  back_stat_t           back_stat;

  // Register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_COLUMN_COUNT: column_count_nxt = pwdata[COL_REG_W-1:0];
        REG_ROW_COUNT:    row_count_nxt    = pwdata[ROW_REG_W-1:0];
        default:          column_count_nxt = column_count_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_COLUMN_COUNT: prdata = PDATA_W'(column_count_r);
      REG_ROW_COUNT:    prdata = PDATA_W'(row_count_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= COL_REG_RESET;
      row_count_r    <= ROW_REG_RESET;
    end else begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

  // Register values above the store size saturate.
  assign cols_ext  = COORD_W'(column_count_r);
  assign rows_ext  = COORD_W'(row_count_r);
  assign geom.cols = (cols_ext > MAX_COLS_C) ? MAX_COLS_C : cols_ext;
  assign geom.rows = (rows_ext > MAX_ROWS_C) ? MAX_ROWS_C : rows_ext;

  tcb_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_cell_value  (in_cell_value),
    .in_line_count  (in_line_count),
    .in_attribute   (in_attribute),
    .geom           (geom),
    .q_full         (q_full),
    .init_done      (back_stat.init_done),
    .push           (push),
    .entry          (entry)
  );

  tcb_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (entry),
    .pop   (back_stat.pop),
    .head  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  tcb_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .geom           (geom),
    .head           (head),
    .q_empty        (q_empty),
    .stat           (back_stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value)
  );

  `TCB_ASSERT_IMPL(a_pop_nonempty, back_stat.pop, !q_empty, "pop from empty command queue")
  `TCB_ASSERT_IMPL(a_no_accept_in_init, !back_stat.init_done, !in_ready, "accept during sweep")
  `TCB_ASSERT_IMPL(a_result_after_init, $rose(out_valid), back_stat.init_done, "early result")
  `TCB_ASSERT_NEXT(a_push_fills, push && !back_stat.pop, !q_empty, "queue lost a command")

endmodule
